FILE: design/ptsr_pkg.sv
package ptsr_pkg;

  localparam int PRICE_W         = 24;
  localparam int REC_W           = 7;
  localparam int FUNC_W          = 2;
  localparam int MAX_ENTRIES_DEF = 64;

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SORT   = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [REC_W-1:0]   rec;
    logic [PRICE_W-1:0] price;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // compare unit result: x >= lo and x <= hi
  typedef struct packed {
    logic ge_lo;
    logic le_hi;
  } cmp_res_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SORT_RA  = 10'b00_0000_0010,
    S_SORT_LA  = 10'b00_0000_0100,
    S_SORT_RB  = 10'b00_0000_1000,
    S_SORT_CB  = 10'b00_0001_0000,
    S_SORT_WA  = 10'b00_0010_0000,
    S_LIST_RD  = 10'b00_0100_0000,
    S_LIST_OUT = 10'b00_1000_0000,
    S_FIND_RD  = 10'b01_0000_0000,
    S_FIND_CHK = 10'b10_0000_0000
  } state_t;

endpackage

FILE: design/ptsr_ram.sv
module ptsr_ram #(
  parameter int WIDTH = ptsr_pkg::ENTRY_W,
  parameter int DEPTH = ptsr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ptsr_cmp.sv
// Shared range compare: used for the sort's greater-than test and the find.
module ptsr_cmp (
  input  logic [ptsr_pkg::PRICE_W-1:0] x,
  input  logic [ptsr_pkg::PRICE_W-1:0] lo,
  input  logic [ptsr_pkg::PRICE_W-1:0] hi,
  output ptsr_pkg::cmp_res_t           res
);

  assign res.ge_lo = (x >= lo);
  assign res.le_hi = (x <= hi);

endmodule

FILE: design/price_table_sort_and_range_find_top.sv
// Channel   Handshake                  Payload
// -------   -------------------------  --------------------------------------------
// command   start / busy (start&!busy)  func, price, low_price, high_price
// result    result_valid (1-cycle)      record_no, price_out, found, table_full, last
//
// Append and clear finish in the accept cycle; append's result shows the next cycle.
// Find: a read and a check per entry; result on the cycle after the hit or the end.
// Sort: per outer entry a read and load, then a read and compare per later entry,
// and a write-back; then a read and an output per listed item (one-read-port RAM).
// rst (synchronous) empties the table and idles the sequencer; no clearing pass.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
module price_table_sort_and_range_find_top #(
  parameter int MAX_ENTRIES = ptsr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptsr_pkg::FUNC_W-1:0]   func,
  input  logic [ptsr_pkg::PRICE_W-1:0]  price,
  input  logic [ptsr_pkg::PRICE_W-1:0]  low_price,
  input  logic [ptsr_pkg::PRICE_W-1:0]  high_price,
  output logic                          result_valid,
  output logic [ptsr_pkg::REC_W-1:0]    record_no,
  output logic [ptsr_pkg::PRICE_W-1:0]  price_out,
  output logic                          found,
  output logic                          table_full,
  output logic                          last
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  ptsr_pkg::state_t state, state_next;

  // entry_count, outer index (a) and the shared scan index (b / find / list)
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] a_idx, a_idx_next;
  logic [CNT_W-1:0] idx, idx_next;

  // the entry held at position a during one inner sort pass
  ptsr_pkg::entry_t cur, cur_next;

  // search bounds latched at accept
  logic [ptsr_pkg::PRICE_W-1:0] lo_q, lo_next;
  logic [ptsr_pkg::PRICE_W-1:0] hi_q, hi_next;

  // result register
  logic                         rv_next;
  logic [ptsr_pkg::REC_W-1:0]   rec_next;
  logic [ptsr_pkg::PRICE_W-1:0] pr_next;
  logic                         found_next, full_next, last_next;

  // RAM ports
  logic                         we;
  logic [IDX_W-1:0]             waddr, raddr;
  ptsr_pkg::entry_t             wdata, rentry;
  logic [ptsr_pkg::ENTRY_W-1:0] rdata;

  // compare unit
  logic [ptsr_pkg::PRICE_W-1:0] cmp_lo;
  ptsr_pkg::cmp_res_t           cmp;
  logic                         accept;
  logic                         idx_is_last;

  ptsr_ram #(
    .WIDTH (ptsr_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry = ptsr_pkg::entry_t'(rdata);

  // sort: stored price < cur  <=>  cur > stored price (swap)
  assign cmp_lo = (state == ptsr_pkg::S_SORT_CB) ? cur.price : lo_q;

  ptsr_cmp u_cmp (
    .x   (rentry.price),
    .lo  (cmp_lo),
    .hi  (hi_q),
    .res (cmp)
  );

  assign busy        = (state != ptsr_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign idx_is_last = ((idx + CNT_W'(1)) == count);
  assign raddr       = (state == ptsr_pkg::S_SORT_RA) ? a_idx[IDX_W-1:0] : idx[IDX_W-1:0];

  always_comb begin
    state_next = state;
    count_next = count;
    a_idx_next = a_idx;
    idx_next   = idx;
    cur_next   = cur;
    lo_next    = lo_q;
    hi_next    = hi_q;
    rv_next    = 1'b0;
    rec_next   = '0;
    pr_next    = '0;
    found_next = 1'b0;
    full_next  = 1'b0;
    last_next  = 1'b1;
    we         = 1'b0;
    waddr      = idx[IDX_W-1:0];
    wdata      = cur;

    case (state)
      ptsr_pkg::S_IDLE: begin
        if (accept) begin
          lo_next = low_price;
          hi_next = high_price;
          case (ptsr_pkg::func_t'(func))
            ptsr_pkg::FUNC_APPEND: begin
              rv_next = 1'b1;
              if (count == CNT_W'(MAX_ENTRIES)) begin
                full_next = 1'b1;
              end else begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata.rec  = ptsr_pkg::REC_W'(count) + ptsr_pkg::REC_W'(1);
                wdata.price = price;
                rec_next   = ptsr_pkg::REC_W'(count) + ptsr_pkg::REC_W'(1);
                pr_next    = price;
                found_next = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            ptsr_pkg::FUNC_SORT: begin
              idx_next   = '0;
              a_idx_next = '0;
              if (count == '0) begin
                rv_next = 1'b1;
              end else if (count == CNT_W'(1)) begin
                state_next = ptsr_pkg::S_LIST_RD;
              end else begin
                state_next = ptsr_pkg::S_SORT_RA;
              end
            end
            ptsr_pkg::FUNC_FIND: begin
              idx_next = '0;
              if (count == '0) begin
                rv_next = 1'b1;
              end else begin
                state_next = ptsr_pkg::S_FIND_RD;
              end
            end
            ptsr_pkg::FUNC_CLEAR: begin
              count_next = '0;
            end
            default: begin
              count_next = count;
            end
          endcase
        end
      end

      ptsr_pkg::S_SORT_RA: begin
        state_next = ptsr_pkg::S_SORT_LA;
      end

      ptsr_pkg::S_SORT_LA: begin
        cur_next   = rentry;
        idx_next   = a_idx + CNT_W'(1);
        state_next = ptsr_pkg::S_SORT_RB;
      end

      ptsr_pkg::S_SORT_RB: begin
        state_next = ptsr_pkg::S_SORT_CB;
      end

      ptsr_pkg::S_SORT_CB: begin
        // strict greater: swap when entry b is below the held entry
        if (!cmp.ge_lo) begin
          we       = 1'b1;
          waddr    = idx[IDX_W-1:0];
          wdata    = cur;
          cur_next = rentry;
        end
        if (idx_is_last) begin
          state_next = ptsr_pkg::S_SORT_WA;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ptsr_pkg::S_SORT_RB;
        end
      end

      ptsr_pkg::S_SORT_WA: begin
        we    = 1'b1;
        waddr = a_idx[IDX_W-1:0];
        wdata = cur;
        if ((a_idx + CNT_W'(2)) == count) begin
          idx_next   = '0;
          state_next = ptsr_pkg::S_LIST_RD;
        end else begin
          a_idx_next = a_idx + CNT_W'(1);
          state_next = ptsr_pkg::S_SORT_RA;
        end
      end

      ptsr_pkg::S_LIST_RD: begin
        state_next = ptsr_pkg::S_LIST_OUT;
      end

      ptsr_pkg::S_LIST_OUT: begin
        rv_next    = 1'b1;
        rec_next   = rentry.rec;
        pr_next    = rentry.price;
        found_next = 1'b1;
        last_next  = idx_is_last;
        if (idx_is_last) begin
          state_next = ptsr_pkg::S_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ptsr_pkg::S_LIST_RD;
        end
      end

      ptsr_pkg::S_FIND_RD: begin
        state_next = ptsr_pkg::S_FIND_CHK;
      end

      ptsr_pkg::S_FIND_CHK: begin
        if (cmp.ge_lo && cmp.le_hi) begin
          rv_next    = 1'b1;
          rec_next   = rentry.rec;
          pr_next    = rentry.price;
          found_next = 1'b1;
          state_next = ptsr_pkg::S_IDLE;
        end else if (idx_is_last) begin
          rv_next    = 1'b1;
          state_next = ptsr_pkg::S_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ptsr_pkg::S_FIND_RD;
        end
      end

      default: begin
        state_next = ptsr_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptsr_pkg::S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= rv_next;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    a_idx      <= a_idx_next;
    idx        <= idx_next;
    cur        <= cur_next;
    lo_q       <= lo_next;
    hi_q       <= hi_next;
    record_no  <= rec_next;
    price_out  <= pr_next;
    found      <= found_next;
    table_full <= full_next;
    last       <= last_next;
  end

endmodule

FILE: design/ptsr_chk.sv
module ptsr_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [ptsr_pkg::FUNC_W-1:0]  func,
  input logic                         result_valid,
  input logic [ptsr_pkg::REC_W-1:0]   record_no,
  input logic [ptsr_pkg::PRICE_W-1:0] price_out,
  input logic                         found,
  input logic                         table_full,
  input logic                         last
);

  // a miss or a dropped append names no entry
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (record_no == '0) && (price_out == '0))
    else $error("miss result carries entry data");

  // a dropped append is a single final item with nothing found
  a_full_final: assert property (@(posedge clk) disable iff (rst)
    (result_valid && table_full) |-> (last && !found))
    else $error("table_full on a non-final or found item");

  // clear produces no item
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == ptsr_pkg::FUNC_CLEAR)) |=> !result_valid)
    else $error("result after clear");

  // more items to come means the command is still running
  a_list_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final item while idle");

  // every found entry has a 1-based record number
  a_found_rec: assert property (@(posedge clk) disable iff (rst)
    (result_valid && found) |-> (record_no != '0))
    else $error("found item with record number zero");

endmodule

bind price_table_sort_and_range_find_top ptsr_chk u_ptsr_chk (.*);
